FILE: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MPA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define MPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/mpa_pkg.sv
// types, constants and reduction functions for the mod 239 arithmetic unit
`timescale 1ns / 1ps
package mpa_pkg;

   localparam int ResWidth       = 8;
   localparam int ExpWidth       = 16;
   localparam int ExpBitsDefault = 16;
   localparam int InvBits        = 8;

   localparam logic [7:0]          Mod8        = 8'd239;
   localparam logic [8:0]          Mod9        = 9'd239;
   localparam logic [9:0]          TwoMod10    = 10'd478;
   localparam logic [ExpWidth-1:0] InvExponent = 16'd237;

   localparam logic [2:0] OpAdd = 3'd0;
   localparam logic [2:0] OpSub = 3'd1;
   localparam logic [2:0] OpMul = 3'd2;
   localparam logic [2:0] OpQuo = 3'd3;
   localparam logic [2:0] OpInv = 3'd4;
   localparam logic [2:0] OpPow = 3'd5;

   typedef struct packed {
      logic [2:0]          op;
      logic                lt;
      logic                eq;
      logic                err;
      logic [7:0]          fixed;
      logic [7:0]          acc;
      logic [7:0]          sq;
      logic [ExpWidth-1:0] e;
      logic [7:0]          divisor;
      logic [7:0]          rem;
      logic [7:0]          quo;
   } stage_type;

   // 8-bit value into 0..238
   function automatic logic [7:0] red_byte(input logic [7:0] v);
      logic [7:0] r;
      r = (v >= Mod8) ? (v - Mod8) : v;
      return r;
   endfunction

   // 16-bit product into 0..238, using 256 = 17 mod 239
   function automatic logic [7:0] red_prod(input logic [15:0] x);
      logic [12:0] t1;
      logic [9:0]  t2;
      logic [7:0]  r;
      t1 = {5'b0, x[15:8]} + {1'b0, x[15:8], 4'b0} + {5'b0, x[7:0]};
      t2 = {5'b0, t1[12:8]} + {1'b0, t1[12:8], 4'b0} + {2'b0, t1[7:0]};
      if (t2 >= TwoMod10) begin
         r = 8'(t2 - TwoMod10);
      end else if (t2 >= {1'b0, Mod9}) begin
         r = 8'(t2 - {1'b0, Mod9});
      end else begin
         r = t2[7:0];
      end
      return r;
   endfunction

endpackage

FILE: design/mpa_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface mpa_req_if import mpa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [2:0]          opcode;
   logic [7:0]          operand_a;
   logic [7:0]          operand_b;
   logic [ExpWidth-1:0] exponent;

   modport source (output valid, output opcode, output operand_a, output operand_b,
                   output exponent, input ready);
   modport sink   (input valid, input opcode, input operand_a, input operand_b,
                   input exponent, output ready);
endinterface

interface mpa_rsp_if import mpa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ResWidth-1:0] result;
   logic                a_less_than_b;
   logic                a_equals_b;
   logic                error_flag;

   modport source (output valid, output result, output a_less_than_b, output a_equals_b,
                   output error_flag, input ready);
   modport sink   (input valid, input result, input a_less_than_b, input a_equals_b,
                   input error_flag, output ready);
endinterface

FILE: design/mpa_stage.sv
// one exponent bit: multiply stage then reduce stage, with one quotient bit step for bits 0 to 7
`timescale 1ns / 1ps
module mpa_stage import mpa_pkg::*; #(
   parameter int BIT_IDX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      in_valid,
   input  stage_type in_item,
   output logic      out_valid,
   output stage_type out_item
);

   localparam bit DivStep = (BIT_IDX < ResWidth);

   stage_type   mid_ff, mid_in;
   logic        mid_vld_ff;
   logic [15:0] pacc_ff, pacc_in;
   logic [15:0] psq_ff, psq_in;
   stage_type   out_ff, out_in;
   logic        out_vld_ff;
   logic [8:0]  rem_sh;
   logic        qbit;

   always_comb begin
      mid_in  = in_item;
      psq_in  = {8'b0, in_item.sq} * {8'b0, in_item.sq};
      pacc_in = in_item.e[BIT_IDX] ? ({8'b0, in_item.acc} * {8'b0, in_item.sq})
                                   : {8'b0, in_item.acc};
      rem_sh  = {in_item.rem, in_item.quo[7]};
      qbit    = (rem_sh >= {1'b0, in_item.divisor});
      if (DivStep) begin
         mid_in.quo = {in_item.quo[6:0], qbit};
         mid_in.rem = qbit ? 8'(rem_sh - {1'b0, in_item.divisor}) : rem_sh[7:0];
      end
   end

   always_comb begin
      out_in     = mid_ff;
      out_in.acc = red_prod(pacc_ff);
      out_in.sq  = red_prod(psq_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         mid_vld_ff <= in_valid;
         out_vld_ff <= mid_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mid_ff  <= mid_in;
         pacc_ff <= pacc_in;
         psq_ff  <= psq_in;
         out_ff  <= out_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_item  = out_ff;

endmodule

FILE: design/mod_prime_alu.sv
// mod 239 arithmetic unit: top level with entry stage and exponent-bit pipeline
// throughput: one item per cycle while output items are taken; every opcode runs the same pipeline
// power and inverse take one multiply and one reduce stage per exponent bit
// the whole pipeline stalls while a valid output item is not taken
// reset is synchronous and clears only the valid bits
`timescale 1ns / 1ps
module mod_prime_alu import mpa_pkg::*; #(
   parameter int EXP_BITS = ExpBitsDefault
) (
   input logic       clock,
   input logic       reset,
   mpa_req_if.sink   req,
   mpa_rsp_if.source rsp
);

   localparam int UseBits = (EXP_BITS < ExpWidth) ? EXP_BITS : ExpWidth;
   localparam int PowBits = (UseBits > InvBits) ? UseBits : InvBits;
   localparam logic [ExpWidth-1:0] ExpMask = ExpWidth'((64'd1 << UseBits) - 64'd1);

   logic       advance;
   logic [7:0] a_red, b_red;
   logic [8:0] sum9;
   logic [7:0] sum_mod, diff_mod;
   stage_type  entry_ff, entry_in;
   logic       entry_vld_ff;
   stage_type  chain [0:PowBits];
   logic       vld [0:PowBits];
   stage_type  last;

   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance && !reset;

   always_comb begin
      a_red    = red_byte(req.operand_a);
      b_red    = red_byte(req.operand_b);
      sum9     = {1'b0, a_red} + {1'b0, b_red};
      sum_mod  = (sum9 >= Mod9) ? 8'(sum9 - Mod9) : sum9[7:0];
      diff_mod = (a_red >= b_red) ? (a_red - b_red)
                                  : 8'({1'b0, a_red} + Mod9 - {1'b0, b_red});

      entry_in         = '0;
      entry_in.op      = req.opcode;
      entry_in.lt      = (a_red < b_red);
      entry_in.eq      = (a_red == b_red);
      entry_in.divisor = b_red;
      entry_in.quo     = a_red;
      entry_in.sq      = b_red;
      case (req.opcode)
         OpAdd: entry_in.fixed = sum_mod;
         OpSub: entry_in.fixed = diff_mod;
         OpMul: begin
            entry_in.acc = a_red;
            entry_in.e   = ExpWidth'(1);
         end
         OpQuo: entry_in.err = (b_red == 8'd0);
         OpInv: begin
            entry_in.err = (b_red == 8'd0);
            entry_in.acc = 8'd1;
            entry_in.e   = InvExponent;
         end
         OpPow: begin
            entry_in.acc = 8'd1;
            entry_in.e   = req.exponent & ExpMask;
         end
         default: entry_in.fixed = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= 1'b0;
      end else if (advance) begin
         entry_vld_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign chain[0] = entry_ff;
   assign vld[0]   = entry_vld_ff;

   for (genvar k = 0; k < PowBits; k++) begin : g_bit
      mpa_stage #(.BIT_IDX(k)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (vld[k]),
         .in_item   (chain[k]),
         .out_valid (vld[k+1]),
         .out_item  (chain[k+1])
      );
   end

   assign last              = chain[PowBits];
   assign rsp.valid         = vld[PowBits];
   assign rsp.a_less_than_b = last.lt;
   assign rsp.a_equals_b    = last.eq;
   assign rsp.error_flag    = last.err;

   always_comb begin
      case (last.op)
         OpAdd, OpSub:        rsp.result = last.fixed;
         OpMul, OpInv, OpPow: rsp.result = last.acc;
         OpQuo:               rsp.result = last.err ? 8'd0 : last.quo;
         default:             rsp.result = 8'd0;
      endcase
   end

endmodule

FILE: design/mpa_checker.sv
// port-level checker for the mod 239 arithmetic unit and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mpa_checker import mpa_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [ResWidth-1:0] rsp_result,
   input logic                rsp_a_less_than_b,
   input logic                rsp_a_equals_b,
   input logic                rsp_error_flag
);

   `MPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result))
   `MPA_ASSERT_IMP(a_result_range, clock, reset, rsp_valid, rsp_result <= 8'd238)
   `MPA_ASSERT_IMP(a_error_zero, clock, reset, rsp_valid && rsp_error_flag, rsp_result == 8'd0)
   `MPA_ASSERT_IMP(a_flags_excl, clock, reset, rsp_valid && rsp_a_equals_b, !rsp_a_less_than_b)

endmodule

bind mod_prime_alu mpa_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_result        (rsp.result),
   .rsp_a_less_than_b (rsp.a_less_than_b),
   .rsp_a_equals_b    (rsp.a_equals_b),
   .rsp_error_flag    (rsp.error_flag)
);
